FILE: rtl/dcfp_pkg.sv
// shared types, constants and code classifiers for the data capture frame parser
`timescale 1ns / 1ps
package dcfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 2;

	localparam logic [KindW-1:0] KIND_EVENT   = 2'd0;
	localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd2;

	localparam logic [ByteW-1:0] CODE_IDLE       = 8'h00;
	localparam logic [ByteW-1:0] CODE_EVT_A      = 8'h04;
	localparam logic [ByteW-1:0] CODE_EVT_B      = 8'h07;
	localparam logic [ByteW-1:0] CODE_EVT_LO     = 8'h20;
	localparam logic [ByteW-1:0] CODE_EVT_HI     = 8'h5F;
	localparam logic [ByteW-1:0] CODE_MSG_LO     = 8'h60;
	localparam logic [ByteW-1:0] CODE_MSG_SPC_LO = 8'h63;
	localparam logic [ByteW-1:0] CODE_MSG_HI     = 8'h66;
	localparam logic [ByteW-1:0] CHAR_SPACE      = 8'h20;

	typedef struct packed {
		logic             valid;
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] code;
		logic [ByteW-1:0] payload;
		logic [ByteW-1:0] byte_index;
		logic             last;
	} dcfp_res_t;

	function automatic logic is_event_code(input logic [ByteW-1:0] c);
		return (c == CODE_EVT_A) || (c == CODE_EVT_B) ||
			((c >= CODE_EVT_LO) && (c <= CODE_EVT_HI));
	endfunction

	function automatic logic is_message_code(input logic [ByteW-1:0] c);
		return (c >= CODE_MSG_LO) && (c <= CODE_MSG_HI);
	endfunction

endpackage

FILE: rtl/data_capture_frame_parser_unit.sv
// data capture frame parser: top level with result register and handshake
//
// Input channel (in_valid/in_ready/raw_byte) takes one raw byte from the
// data-capture serial line per transfer. A byte counts only when it repeats
// the byte before it; counted bytes drive the code/length/payload parser.
// Output channel (out_valid/out_ready) carries at most one result per input
// byte: an event, a message payload byte with index and last flag, or an
// unknown code that was dropped. Bytes that produce nothing give no transfer.
// Latency: the result of a byte is valid in the cycle after its transfer.
// Throughput: one byte per cycle unless stalled; the decode is a single
// compare/increment stage between the parser state and the result register.
// Stall: in_ready stays high while the result register is empty or is
// being taken in the same cycle; with a full register and out_ready low,
// in_ready drops and the pending result holds unchanged.
// Reset (arst_n low, asynchronous) clears the byte history, returns the
// parser to idle and empties the result register.
`timescale 1ns / 1ps
module data_capture_frame_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dcfp_pkg::ByteW-1:0] raw_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dcfp_pkg::KindW-1:0] kind,
	output logic [dcfp_pkg::ByteW-1:0] code,
	output logic [dcfp_pkg::ByteW-1:0] payload,
	output logic [dcfp_pkg::ByteW-1:0] byte_index,
	output logic                       last
);
	import dcfp_pkg::*;

	dcfp_res_t res;
	logic      accept;
	logic      out_valid_q;
	dcfp_res_t res_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	dcfp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.raw_byte (raw_byte),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= accept && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = res_q.kind;
	assign code       = res_q.code;
	assign payload    = res_q.payload;
	assign byte_index = res_q.byte_index;
	assign last       = res_q.last;

`ifndef SYNTHESIS
	a_event_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_EVENT) |-> (last && payload == '0 && byte_index == '0))
		else $error("event result with payload fields set");

	a_unknown_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_UNKNOWN) |-> (last && payload == '0 && byte_index == '0))
		else $error("unknown-code result with payload fields set");

	a_payload_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_PAYLOAD) |-> (code >= CODE_MSG_LO && code <= CODE_MSG_HI))
		else $error("payload result outside message code range");

	a_no_kind3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_EVENT || kind == KIND_PAYLOAD || kind == KIND_UNKNOWN))
		else $error("result with undefined kind");
`endif

endmodule

FILE: rtl/dcfp_core.sv
// parser state registers and the per-byte decode that produces at most one result
`timescale 1ns / 1ps
module dcfp_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [dcfp_pkg::ByteW-1:0] raw_byte,
	output dcfp_pkg::dcfp_res_t       res
);
	import dcfp_pkg::*;

	logic [ByteW-1:0] prev_raw_q;
	logic [ByteW-1:0] code_q;
	logic [ByteW-1:0] exp_len_q;
	logic [ByteW-1:0] rcv_cnt_q;

	logic [ByteW-1:0] code_d;
	logic [ByteW-1:0] exp_len_d;
	logic [ByteW-1:0] rcv_cnt_d;
	logic [ByteW-1:0] cnt_inc;
	logic             counted;

	assign counted = (raw_byte == prev_raw_q);
	assign cnt_inc = rcv_cnt_q + 8'd1;

	always_comb begin
		code_d    = code_q;
		exp_len_d = exp_len_q;
		rcv_cnt_d = rcv_cnt_q;
		res       = '0;
		res.code  = code_q;
		if (counted) begin
			if (code_q == CODE_IDLE) begin
				code_d = raw_byte;
			end else if (is_event_code(code_q)) begin
				code_d    = CODE_IDLE;
				res.valid = 1'b1;
				res.kind  = KIND_EVENT;
				res.last  = 1'b1;
			end else if (is_message_code(code_q)) begin
				if (exp_len_q == '0) begin
					rcv_cnt_d = '0;
					exp_len_d = raw_byte;
				end else begin
					res.valid      = 1'b1;
					res.kind       = KIND_PAYLOAD;
					res.payload    = raw_byte;
					if ((code_q >= CODE_MSG_SPC_LO) && (raw_byte == '0))
						res.payload = CHAR_SPACE;
					res.byte_index = rcv_cnt_q;
					res.last       = (cnt_inc == exp_len_q);
					rcv_cnt_d      = cnt_inc;
					if (res.last) begin
						code_d    = CODE_IDLE;
						exp_len_d = '0;
					end
				end
			end else begin
				code_d    = CODE_IDLE;
				res.valid = 1'b1;
				res.kind  = KIND_UNKNOWN;
				res.last  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= '0;
			code_q     <= CODE_IDLE;
			exp_len_q  <= '0;
			rcv_cnt_q  <= '0;
		end else if (accept) begin
			prev_raw_q <= raw_byte;
			code_q     <= code_d;
			exp_len_q  <= exp_len_d;
			rcv_cnt_q  <= rcv_cnt_d;
		end
	end

endmodule
